// ----- rtl/bmsirq_pkg.sv -----
// ----------------------------------------------------------------------------
// bmsirq_pkg
// shared types and constants of the bank mapper with scanline interrupt
// ----------------------------------------------------------------------------
package bmsirq_pkg;

  // bus item kinds
  typedef enum logic [1:0] {
    REQ_TICK      = 2'd0,
    REQ_CPU_WRITE = 2'd1,
    REQ_CPU_XLATE = 2'd2,
    REQ_PPU_XLATE = 2'd3
  } req_kind_t;

  // translation targets
  typedef enum logic [2:0] {
    TGT_PRG_ROM    = 3'd0,
    TGT_PRG_RAM    = 3'd1,
    TGT_OPEN_BUS   = 3'd2,
    TGT_CHR_ROM    = 3'd3,
    TGT_CHR_RAM    = 3'd4,
    TGT_NOT_MAPPED = 3'd5
  } target_t;

  // configuration register indexes
  localparam logic [1:0] CFG_CHR_IS_ROM    = 2'd0;
  localparam logic [1:0] CFG_PRG_BANK_MASK = 2'd1;
  localparam logic [1:0] CFG_CHR_BANK_MASK = 2'd2;

  // register pages of the cpu write decode (addr bits 14..12 with bit 15 set)
  localparam logic [2:0] PAGE_PRG01   = 3'd0;
  localparam logic [2:0] PAGE_PRG2    = 3'd1;
  localparam logic [2:0] PAGE_CHR01   = 3'd2;
  localparam logic [2:0] PAGE_CHR23   = 3'd3;
  localparam logic [2:0] PAGE_CHR45   = 3'd4;
  localparam logic [2:0] PAGE_CHR67   = 3'd5;
  localparam logic [2:0] PAGE_MISC    = 3'd6;
  localparam logic [2:0] PAGE_IRQ     = 3'd7;

  localparam logic [9:0]  PRESCALE_PERIOD = 10'd341;
  localparam logic [9:0]  PRESCALE_STEP   = 10'd3;
  localparam logic [15:0] REG_SEL_MASK    = 16'h0018;
  localparam logic [7:0]  LAST_PRG_BANK   = 8'hFF;
  localparam logic [7:0]  PRG_BANK_RESET2 = 8'hFE;
  localparam logic [7:0]  CHR_RAM_MASK    = 8'h07;

  // irq control bits
  localparam int unsigned CTRL_ACK_EN = 0;
  localparam int unsigned CTRL_EN     = 1;
  localparam int unsigned CTRL_CYCLE  = 2;

  typedef struct packed {
    req_kind_t   kind;
    logic [15:0] addr;
    logic [7:0]  data;
  } req_t;

  typedef struct packed {
    logic [2:0][7:0] prg_bank;
    logic [7:0][7:0] chr_bank;
    logic [7:0]      misc;
  } bank_state_t;

  typedef struct packed {
    logic       chr_is_rom;
    logic [7:0] prg_bank_mask;
    logic [7:0] chr_bank_mask;
  } map_cfg_t;

endpackage

// ----- rtl/bmsirq_regs.sv -----
// ----------------------------------------------------------------------------
// bmsirq_regs
// mapper state: bank registers, misc register and the irq counter
// ----------------------------------------------------------------------------
module bmsirq_regs (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  bmsirq_pkg::req_t       req,
  output bmsirq_pkg::bank_state_t st,
  output logic                   irq_nxt,
  output logic [7:0]             misc_nxt,
  output logic                   sound
);

  logic [2:0]              irq_control_r, irq_control_nxt;
  logic [7:0]              irq_reload_r, irq_reload_nxt;
  logic [7:0]              irq_count_r, irq_count_nxt;
  logic [9:0]              prescale_r, prescale_nxt;
  logic                    irq_line_r, irq_line_nxt;
  bmsirq_pkg::bank_state_t bank_r, bank_nxt;
  logic                    hi;
  logic                    fire;
  logic [2:0]              ctrl_wr;

  assign hi = (req.addr & bmsirq_pkg::REG_SEL_MASK) != 16'd0;
  assign ctrl_wr = req.data[2:0];

  always_comb begin
    irq_control_nxt = irq_control_r;
    irq_reload_nxt  = irq_reload_r;
    irq_count_nxt   = irq_count_r;
    prescale_nxt    = prescale_r;
    irq_line_nxt    = irq_line_r;
    bank_nxt        = bank_r;
    sound           = 1'b0;
    fire            = 1'b0;
    unique case (req.kind)
      bmsirq_pkg::REQ_TICK: begin
        if (irq_control_r[bmsirq_pkg::CTRL_EN]) begin
          if (irq_control_r[bmsirq_pkg::CTRL_CYCLE]) begin
            fire = 1'b1;
          end else if (prescale_r < bmsirq_pkg::PRESCALE_STEP) begin
            fire = 1'b1;
            prescale_nxt = prescale_r + (bmsirq_pkg::PRESCALE_PERIOD
                                         - bmsirq_pkg::PRESCALE_STEP);
          end else begin
            prescale_nxt = prescale_r - bmsirq_pkg::PRESCALE_STEP;
          end
          if (fire) begin
            if (irq_count_r == 8'hFF) begin
              irq_count_nxt = irq_reload_r;
              irq_line_nxt  = 1'b1;
            end else begin
              irq_count_nxt = irq_count_r + 8'd1;
            end
          end
        end
      end
      bmsirq_pkg::REQ_CPU_WRITE: begin
        if (req.addr[15]) begin
          unique case (req.addr[14:12])
            bmsirq_pkg::PAGE_PRG01: bank_nxt.prg_bank[{1'b0, hi}] = req.data;
            bmsirq_pkg::PAGE_PRG2: begin
              if (hi) sound = 1'b1;
              else    bank_nxt.prg_bank[2] = req.data;
            end
            bmsirq_pkg::PAGE_CHR01: bank_nxt.chr_bank[{2'b00, hi}] = req.data;
            bmsirq_pkg::PAGE_CHR23: bank_nxt.chr_bank[{2'b01, hi}] = req.data;
            bmsirq_pkg::PAGE_CHR45: bank_nxt.chr_bank[{2'b10, hi}] = req.data;
            bmsirq_pkg::PAGE_CHR67: bank_nxt.chr_bank[{2'b11, hi}] = req.data;
            bmsirq_pkg::PAGE_MISC: begin
              if (hi) irq_reload_nxt = req.data;
              else    bank_nxt.misc  = req.data;
            end
            bmsirq_pkg::PAGE_IRQ: begin
              if (hi) begin
                if (irq_control_r[bmsirq_pkg::CTRL_ACK_EN]) begin
                  irq_control_nxt[bmsirq_pkg::CTRL_EN] = 1'b1;
                end
              end else begin
                irq_control_nxt = ctrl_wr;
                if (ctrl_wr[bmsirq_pkg::CTRL_EN]) begin
                  irq_count_nxt = irq_reload_r;
                  prescale_nxt  = bmsirq_pkg::PRESCALE_PERIOD;
                end
              end
              irq_line_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      irq_control_r     <= 3'd0;
      irq_reload_r      <= 8'd0;
      irq_count_r       <= 8'd0;
      prescale_r        <= bmsirq_pkg::PRESCALE_PERIOD;
      irq_line_r        <= 1'b0;
      bank_r.prg_bank[0] <= 8'd0;
      bank_r.prg_bank[1] <= 8'd1;
      bank_r.prg_bank[2] <= bmsirq_pkg::PRG_BANK_RESET2;
      for (int i = 0; i < 8; i++) begin
        bank_r.chr_bank[i] <= 8'(i);
      end
      bank_r.misc       <= 8'd0;
    end else if (en) begin
      irq_control_r <= irq_control_nxt;
      irq_reload_r  <= irq_reload_nxt;
      irq_count_r   <= irq_count_nxt;
      prescale_r    <= prescale_nxt;
      irq_line_r    <= irq_line_nxt;
      bank_r        <= bank_nxt;
    end
  end

  assign st       = bank_r;
  assign irq_nxt  = irq_line_nxt;
  assign misc_nxt = bank_nxt.misc;

endmodule

// ----- rtl/bmsirq_xlate.sv -----
// ----------------------------------------------------------------------------
// bmsirq_xlate
// cpu and ppu address translation through the bank registers
// ----------------------------------------------------------------------------
module bmsirq_xlate (
  input  bmsirq_pkg::req_t        req,
  input  bmsirq_pkg::bank_state_t st,
  input  bmsirq_pkg::map_cfg_t    cfg,
  output logic [20:0]             mapped,
  output bmsirq_pkg::target_t     target
);

  logic [1:0]  prg_slot;
  logic [7:0]  prg_bank;
  logic [13:0] pa;
  logic [7:0]  chr_bank;

  assign prg_slot = req.addr[14:13];
  assign pa       = req.addr[13:0];
  assign chr_bank = st.chr_bank[pa[12:10]];

  always_comb begin
    mapped   = 21'd0;
    target   = bmsirq_pkg::TGT_NOT_MAPPED;
    prg_bank = (prg_slot == 2'd3) ? bmsirq_pkg::LAST_PRG_BANK : st.prg_bank[prg_slot];
    unique case (req.kind)
      bmsirq_pkg::REQ_CPU_XLATE: begin
        if (req.addr[15]) begin
          mapped = {prg_bank & cfg.prg_bank_mask, req.addr[12:0]};
          target = bmsirq_pkg::TGT_PRG_ROM;
        end else if (req.addr[14:13] == 2'b11) begin
          if (st.misc[7]) begin
            mapped = {8'd0, req.addr[12:0]};
            target = bmsirq_pkg::TGT_PRG_RAM;
          end else begin
            target = bmsirq_pkg::TGT_OPEN_BUS;
          end
        end
      end
      bmsirq_pkg::REQ_PPU_XLATE: begin
        if (!pa[13]) begin
          if (cfg.chr_is_rom) begin
            mapped = {3'd0, chr_bank & cfg.chr_bank_mask, pa[9:0]};
            target = bmsirq_pkg::TGT_CHR_ROM;
          end else begin
            mapped = {3'd0, chr_bank & bmsirq_pkg::CHR_RAM_MASK, pa[9:0]};
            target = bmsirq_pkg::TGT_CHR_RAM;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/bank_mapper_with_scanline_irq.sv -----
// ----------------------------------------------------------------------------
// bank_mapper_with_scanline_irq
// cartridge bank mapper with a cycle-driven interrupt counter
// ----------------------------------------------------------------------------
// One bus beat per clock while in_stall is low: a cpu cycle tick, a cpu
// register write, a cpu address translation or a ppu address translation.
// Each beat is captured in an input register; when the result register is
// free or being drained, the single-pass decode/translate logic updates the
// mapper state and loads the result register, so a new beat can be taken
// every clock while in_stall is low. in_stall rises only while both the
// input register and the result register hold data and out_stall is high.
// Configuration (chr_is_rom at 0x0, prg_bank_mask at 0x4, chr_bank_mask at
// 0x8) is written over the apb port and must only change while no beat is
// in flight.
// ----------------------------------------------------------------------------
module bank_mapper_with_scanline_irq (
  input  logic        clk,
  input  logic        rst_n,
  // input beats
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_addr,
  input  logic [7:0]  in_data,
  // result beats
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_irq_asserted,
  output logic [20:0] out_mapped_addr,
  output logic [2:0]  out_target,
  output logic [1:0]  out_mirroring,
  output logic        out_sound_select,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  bmsirq_pkg::map_cfg_t cfg_r;
  logic                 cfg_wr;

  // input register
  logic                 req_vld_r;
  bmsirq_pkg::req_t     req_r;
  logic                 advance;

  // state and translation
  bmsirq_pkg::bank_state_t st;
  logic                 irq_nxt;
  logic [7:0]           misc_nxt;
  logic                 sound;
  logic [20:0]          mapped;
  bmsirq_pkg::target_t  target;

  // result register
  logic                 out_vld_r;
  logic                 irq_r;
  logic [20:0]          mapped_r;
  logic [2:0]           target_r;
  logic [1:0]           mirror_r;
  logic                 sound_r;

  // apb: writes land on the access phase, reads are combinational
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.chr_is_rom    <= 1'b1;
      cfg_r.prg_bank_mask <= 8'hFF;
      cfg_r.chr_bank_mask <= 8'hFF;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        bmsirq_pkg::CFG_CHR_IS_ROM:    cfg_r.chr_is_rom    <= pwdata[0];
        bmsirq_pkg::CFG_PRG_BANK_MASK: cfg_r.prg_bank_mask <= pwdata[7:0];
        bmsirq_pkg::CFG_CHR_BANK_MASK: cfg_r.chr_bank_mask <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      bmsirq_pkg::CFG_CHR_IS_ROM:    prdata = {31'd0, cfg_r.chr_is_rom};
      bmsirq_pkg::CFG_PRG_BANK_MASK: prdata = {24'd0, cfg_r.prg_bank_mask};
      bmsirq_pkg::CFG_CHR_BANK_MASK: prdata = {24'd0, cfg_r.chr_bank_mask};
      default:                       prdata = 32'd0;
    endcase
  end

  // the held beat moves on when the result register is free or being drained
  assign advance  = req_vld_r & (~out_vld_r | ~out_stall);
  assign in_stall = req_vld_r & ~advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else if (!in_stall) begin
      req_vld_r <= in_valid;
    end
  end

  // payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_r.kind <= bmsirq_pkg::req_kind_t'(in_req_type);
      req_r.addr <= in_addr;
      req_r.data <= in_data;
    end
  end

  // state updates only on the edge that moves the beat into the result register
  bmsirq_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (advance),
    .req      (req_r),
    .st       (st),
    .irq_nxt  (irq_nxt),
    .misc_nxt (misc_nxt),
    .sound    (sound)
  );

  // translation sees the state before this beat; translations never change it
  bmsirq_xlate u_xlate (
    .req    (req_r),
    .st     (st),
    .cfg    (cfg_r),
    .mapped (mapped),
    .target (target)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      irq_r    <= irq_nxt;
      mapped_r <= mapped;
      target_r <= target;
      mirror_r <= misc_nxt[1:0];
      sound_r  <= sound;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_irq_asserted = irq_r;
  assign out_mapped_addr  = mapped_r;
  assign out_target       = target_r;
  assign out_mirroring    = mirror_r;
  assign out_sound_select = sound_r;

endmodule

// ----- rtl/bmsirq_checker.sv -----
// ----------------------------------------------------------------------------
// bmsirq_checker
// port-level checks of the bank mapper, bound to the top level
// ----------------------------------------------------------------------------
module bmsirq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [20:0] out_mapped_addr,
  input logic [2:0]  out_target,
  input logic        out_sound_select
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_target_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_target <= bmsirq_pkg::TGT_NOT_MAPPED)
    else $error("target code out of range");

  a_unmapped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_target == bmsirq_pkg::TGT_NOT_MAPPED ||
                  out_target == bmsirq_pkg::TGT_OPEN_BUS) |-> out_mapped_addr == 21'd0)
    else $error("unmapped result carries an address");

  a_chr_ram_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_target == bmsirq_pkg::TGT_CHR_RAM |-> out_mapped_addr[20:13] == 8'd0)
    else $error("pattern ram offset beyond 8k");

  a_sound_no_xlate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sound_select |-> out_target == bmsirq_pkg::TGT_NOT_MAPPED)
    else $error("sound write reported as translation");

endmodule

bind bank_mapper_with_scanline_irq bmsirq_checker u_bmsirq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_mapped_addr  (out_mapped_addr),
  .out_target       (out_target),
  .out_sound_select (out_sound_select)
);
